// ===== hdl/thermal_printer_raster_decoder_top_assert.svh =====
// Assertion macros for the raster decoder.
`ifndef THERMAL_PRINTER_RASTER_DECODER_TOP_ASSERT_SVH
`define THERMAL_PRINTER_RASTER_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TPRD_ASSERT_IMPLIES(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("tprd: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define TPRD_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("tprd: next-cycle check failed");

`endif

// ===== hdl/tprd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tprd_pkg;

	localparam int WINDOW_DEPTH_DEF = 17;
	localparam int COORD_BITS_DEF = 24;
	localparam int IN_FIFO_DEPTH = 4;
	localparam int OUT_FIFO_DEPTH = 4;
	localparam int OUT_TDATA_W = 128;

	localparam int NUM_CMD = 7;
	localparam int NUM_PAT = 9;
	localparam int PAT_LEN = 5;

	// Pattern indexes: commands first, then the two row-abort patterns
	localparam logic [2:0] CMD_GS8L = 3'd0;
	localparam logic [2:0] CMD_GSV0 = 3'd1;
	localparam logic [2:0] CMD_ESC_STAR = 3'd2;
	localparam logic [2:0] CMD_ESC_J = 3'd3;
	localparam logic [2:0] CMD_ESC_DOLLAR = 3'd4;
	localparam logic [2:0] CMD_GS_P = 3'd5;
	localparam logic [2:0] CMD_GS_V = 3'd6;
	localparam int PAT_ABORT_H = 7;
	localparam int PAT_ABORT_V = 8;

	localparam logic [7:0] MODE_VDBL = 8'h01;
	localparam logic [7:0] MODE_TRIPLE = 8'h20;
	localparam logic [7:0] MODE_TRIPLE_DBL = 8'h21;

	localparam logic [1:0] MAX_RESULTS = 2'd3;
	localparam logic [1:0] GS_V_TRAIL = 2'd2;
	localparam logic [23:0] PLACE_COORD = 24'd10;

	localparam logic [2:0] PAT_N [NUM_PAT] = '{3'd5, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
		3'd3, 3'd2};

	localparam logic [4:0] PAT_POS [NUM_PAT][PAT_LEN] = '{
		'{5'd0, 5'd1, 5'd2, 5'd7, 5'd8},
		'{5'd0, 5'd1, 5'd2, 5'd0, 5'd0},
		'{5'd0, 5'd1, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd1, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd1, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd1, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd1, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd1, 5'd2, 5'd0, 5'd0},
		'{5'd0, 5'd1, 5'd0, 5'd0, 5'd0}
	};

	localparam logic [7:0] PAT_VAL [NUM_PAT][PAT_LEN] = '{
		'{8'h1D, 8'h38, 8'h4C, 8'h30, 8'h70},
		'{8'h1D, 8'h76, 8'h30, 8'h00, 8'h00},
		'{8'h1B, 8'h2A, 8'h00, 8'h00, 8'h00},
		'{8'h1B, 8'h4A, 8'h00, 8'h00, 8'h00},
		'{8'h1B, 8'h24, 8'h00, 8'h00, 8'h00},
		'{8'h1D, 8'h50, 8'h00, 8'h00, 8'h00},
		'{8'h1D, 8'h56, 8'h00, 8'h00, 8'h00},
		'{8'h1D, 8'h28, 8'h4C, 8'h00, 8'h00},
		'{8'h1B, 8'h4A, 8'h00, 8'h00, 8'h00}
	};

	// Header length of each command, also the bytes it consumes
	localparam logic [4:0] PAT_HDR [NUM_CMD] = '{5'd17, 5'd8, 5'd5, 5'd3, 5'd4, 5'd4, 5'd2};

	typedef enum logic [2:0] {
		OP_HORIZ = 3'd0,
		OP_VERT = 3'd1,
		OP_VDBL = 3'd2,
		OP_PLACE = 3'd3,
		OP_TEND = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_GS8L,
		PH_GSV0,
		PH_VCOL,
		PH_VTRIPLE
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RUN,
		BK_PLACE,
		BK_TEND,
		BK_FLUSH
	} bk_state_t;

	typedef enum logic [1:0] {
		MR_NO,
		MR_YES,
		MR_WAIT
	} match_t;

	typedef struct packed {
		logic [31:0] stream_offset;
		logic [31:0] pixel_count;
		logic [7:0] image_byte;
		logic [23:0] y_coord;
		logic [23:0] x_coord;
		op_t op;
	} result_t;

	typedef struct packed {
		logic last_result;
		result_t res;
	} out_item_t;

	typedef struct packed {
		logic end_of_data;
		logic [7:0] data_byte;
	} in_item_t;

endpackage
`default_nettype wire

// ===== hdl/tprd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tprd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] push_data,
	input wire logic pop,
	output logic [WIDTH-1:0] pop_data,
	output logic full,
	output logic empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_q];

	// Store the incoming transfer
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/tprd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tprd_parser #(
	parameter int WINDOW_DEPTH = 17,
	parameter int COORD_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire tprd_pkg::in_item_t in_item,
	output logic in_pop,
	input wire logic out_full,
	output logic out_push,
	output tprd_pkg::out_item_t out_item
);
	import tprd_pkg::*;

	localparam int IW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int CB = COORD_BITS;

	// Window and parser state
	logic [7:0] win_q [WINDOW_DEPTH];
	logic [FW-1:0] fill_q;
	phase_t phase_q, phase_d;
	logic [7:0] mode_q, mode_d;
	logic [CB-1:0] x_q, x_d, y_q, y_d, xs_q, xs_d;
	logic [7:0] xsc_q, xsc_d, ysc_q, ysc_d;
	logic [15:0] rows_q, rows_d, rw_q, rw_d, rbl_q, rbl_d;
	logic [1:0] col_q, col_d, skip_q, skip_d;
	logic [31:0] pix_q, pix_d, bytes_q;
	logic end_q;
	logic [1:0] cnt_q;
	logic pend_v_q;
	result_t pend_q;
	bk_state_t state_q, state_d;

	// Step decode
	logic av [WINDOW_DEPTH];
	logic wt [WINDOW_DEPTH];
	logic [7:0] pv [WINDOW_DEPTH];
	match_t mres [NUM_PAT];
	logic dec;
	logic sel_found, sel_wait, hdr_ok;
	logic [2:0] sel_idx;
	logic [15:0] gs8l_bytes, sh_w, sh_h, vcols;
	logic [15:0] feed_amt;
	logic [23:0] ofs_prod;
	logic [31:0] tend_ofs;
	logic [CB-1:0] yy;
	logic dbl;
	logic adv, emit_req;
	logic [FW-1:0] cons_n;
	result_t emit_res, emit_data;
	logic en, run_act, flush, load, place_emit, tend, emit_any, emit_ok;

	// Classify each window slot as present, waiting or past the end
	always_comb begin
		for (int k = 0; k < WINDOW_DEPTH; k++) begin
			av[k] = FW'(k) < fill_q;
			wt[k] = !av[k] && !end_q;
			pv[k] = av[k] ? win_q[k] : 8'h00;
		end
	end

	// Match every pattern against the window
	always_comb begin
		dec = 1'b0;
		for (int p = 0; p < NUM_PAT; p++) begin
			mres[p] = MR_YES;
			dec = 1'b0;
			for (int i = 0; i < PAT_LEN; i++) begin
				if (3'(i) < PAT_N[p] && !dec) begin
					if (wt[IW'(PAT_POS[p][i])]) begin
						mres[p] = MR_WAIT;
						dec = 1'b1;
					end else if (!av[IW'(PAT_POS[p][i])] ||
							win_q[IW'(PAT_POS[p][i])] != PAT_VAL[p][i]) begin
						mres[p] = MR_NO;
						dec = 1'b1;
					end
				end
			end
		end
	end

	// Pick the first command that matches or still waits
	always_comb begin
		sel_found = 1'b0;
		sel_wait = 1'b0;
		sel_idx = CMD_GS8L;
		for (int c = 0; c < NUM_CMD; c++) begin
			if (!sel_found) begin
				if (mres[c] == MR_WAIT) begin
					sel_found = 1'b1;
					sel_wait = 1'b1;
				end else if (mres[c] == MR_YES) begin
					sel_found = 1'b1;
					sel_idx = 3'(c);
				end
			end
		end
		hdr_ok = (fill_q >= FW'(PAT_HDR[sel_idx])) || end_q;
	end

	// Header parameters
	assign gs8l_bytes = 16'((17'({pv[14], pv[13]}) + 17'd7) >> 3);
	assign sh_w = (sel_idx == CMD_GS8L) ? gs8l_bytes : {pv[5], pv[4]};
	assign sh_h = (sel_idx == CMD_GS8L) ? {pv[16], pv[15]} : {pv[7], pv[6]};
	assign vcols = {pv[4], pv[3]};
	assign feed_amt = pv[2] * ysc_q;
	assign ofs_prod = {pv[3], pv[2]} * xsc_q;
	assign tend_ofs = bytes_q - 32'(fill_q) + 32'd4;
	assign dbl = (mode_q == MODE_TRIPLE_DBL);
	assign yy = y_q + CB'(dbl ? {col_q, 4'b0000} : {1'b0, col_q, 3'b000});

	// One parser step on the current window
	always_comb begin
		adv = 1'b0;
		cons_n = '0;
		emit_req = 1'b0;
		emit_res = '0;
		phase_d = phase_q;
		mode_d = mode_q;
		x_d = x_q;
		y_d = y_q;
		xs_d = xs_q;
		xsc_d = xsc_q;
		ysc_d = ysc_q;
		rows_d = rows_q;
		rw_d = rw_q;
		rbl_d = rbl_q;
		col_d = col_q;
		skip_d = skip_q;
		pix_d = pix_q;
		if (skip_q != '0) begin
			// Drop trailing bytes of GS V
			if (fill_q != '0) begin
				cons_n = FW'(1);
				skip_d = skip_q - 1'b1;
				adv = 1'b1;
			end else if (end_q) begin
				skip_d = '0;
			end
		end else if (phase_q == PH_IDLE) begin
			if (fill_q != '0) begin
				if (!sel_found) begin
					cons_n = FW'(1);
					adv = 1'b1;
				end else if (!sel_wait && hdr_ok) begin
					adv = 1'b1;
					cons_n = FW'(PAT_HDR[sel_idx]);
					unique case (sel_idx)
						CMD_GS8L, CMD_GSV0: begin
							x_d = xs_q;
							rw_d = sh_w;
							rbl_d = sh_w;
							rows_d = sh_h;
							if (sh_h == '0) begin
								phase_d = PH_IDLE;
								xs_d = '0;
							end else if (sh_w == '0) begin
								y_d = y_q + CB'(sh_h);
								rows_d = '0;
								phase_d = PH_IDLE;
								xs_d = '0;
							end else begin
								phase_d = (sel_idx == CMD_GS8L) ? PH_GS8L : PH_GSV0;
							end
						end
						CMD_ESC_STAR: begin
							mode_d = pv[2];
							rbl_d = vcols;
							x_d = xs_q;
							col_d = '0;
							if (vcols == '0) begin
								phase_d = PH_IDLE;
								xs_d = '0;
							end else if (pv[2] <= MODE_VDBL) begin
								phase_d = PH_VCOL;
							end else if (pv[2] == MODE_TRIPLE || pv[2] == MODE_TRIPLE_DBL) begin
								phase_d = PH_VTRIPLE;
							end else begin
								phase_d = PH_IDLE;
								xs_d = '0;
							end
						end
						CMD_ESC_J: begin
							y_d = y_q + CB'(feed_amt);
						end
						CMD_ESC_DOLLAR: begin
							xs_d = CB'(ofs_prod);
						end
						CMD_GS_P: begin
							xsc_d = (pv[2] != 8'h00) ? pv[2] : 8'h01;
							ysc_d = (pv[3] != 8'h00) ? pv[3] : 8'h01;
						end
						CMD_GS_V: begin
							skip_d = GS_V_TRAIL;
							if (pix_q != '0) begin
								emit_req = 1'b1;
								emit_res.op = OP_TEND;
								emit_res.pixel_count = pix_q;
								emit_res.stream_offset = tend_ofs;
								phase_d = PH_IDLE;
								mode_d = '0;
								x_d = '0;
								y_d = '0;
								xs_d = '0;
								xsc_d = 8'h01;
								ysc_d = 8'h01;
								rows_d = '0;
								rw_d = '0;
								rbl_d = '0;
								col_d = '0;
								pix_d = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end else if (fill_q == '0 && !end_q) begin
			adv = 1'b0;
		end else if (phase_q == PH_GS8L || phase_q == PH_GSV0) begin
			if (fill_q == '0) begin
				// Starved row: add all rows left
				adv = 1'b1;
				y_d = y_q + CB'(rows_q);
				rows_d = '0;
				phase_d = PH_IDLE;
				xs_d = '0;
			end else if (phase_q == PH_GS8L && mres[PAT_ABORT_H] == MR_WAIT) begin
				adv = 1'b0;
			end else if (phase_q == PH_GS8L && mres[PAT_ABORT_H] == MR_YES) begin
				adv = 1'b1;
				y_d = y_q + CB'(rows_q);
				rows_d = '0;
				phase_d = PH_IDLE;
				xs_d = '0;
			end else begin
				adv = 1'b1;
				cons_n = FW'(1);
				emit_req = 1'b1;
				emit_res.op = OP_HORIZ;
				emit_res.x_coord = 24'(x_q);
				emit_res.y_coord = 24'(y_q);
				emit_res.image_byte = win_q[0];
				pix_d = pix_q + 32'd8;
				if (rbl_q == 16'd1) begin
					y_d = y_q + CB'(1);
					rows_d = rows_q - 1'b1;
					x_d = xs_q;
					rbl_d = rw_q;
					if (rows_q == 16'd1) begin
						phase_d = PH_IDLE;
						xs_d = '0;
					end
				end else begin
					x_d = x_q + CB'(8);
					rbl_d = rbl_q - 1'b1;
				end
			end
		end else begin
			if (fill_q == '0) begin
				adv = 1'b1;
				phase_d = PH_IDLE;
				xs_d = '0;
			end else if (mres[PAT_ABORT_V] == MR_WAIT) begin
				adv = 1'b0;
			end else if (mres[PAT_ABORT_V] == MR_YES) begin
				adv = 1'b1;
				phase_d = PH_IDLE;
				xs_d = '0;
			end else begin
				adv = 1'b1;
				cons_n = FW'(1);
				emit_req = 1'b1;
				emit_res.x_coord = 24'(x_q);
				emit_res.image_byte = win_q[0];
				pix_d = pix_q + 32'd8;
				if (phase_q == PH_VCOL) begin
					emit_res.op = (mode_q == MODE_VDBL) ? OP_VDBL : OP_VERT;
					emit_res.y_coord = 24'(y_q);
					x_d = x_q + CB'(1);
					rbl_d = rbl_q - 1'b1;
					if (rbl_q == 16'd1) begin
						phase_d = PH_IDLE;
						xs_d = '0;
					end
				end else begin
					emit_res.op = dbl ? OP_VDBL : OP_VERT;
					emit_res.y_coord = 24'(yy);
					if (col_q == 2'd2) begin
						col_d = '0;
						x_d = x_q + CB'(1);
						rbl_d = rbl_q - 1'b1;
						if (rbl_q == 16'd1) begin
							phase_d = PH_IDLE;
							xs_d = '0;
						end
					end else begin
						col_d = col_q + 1'b1;
					end
				end
			end
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (en && in_valid) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (en && !adv) begin
					if (end_q) begin
						state_d = BK_PLACE;
					end else begin
						state_d = in_valid ? BK_RUN : BK_IDLE;
					end
				end
			end
			BK_PLACE: begin
				if (en) begin
					state_d = BK_TEND;
				end
			end
			BK_TEND: begin
				if (en) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (en) begin
					state_d = in_valid ? BK_RUN : BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Sequencer actions
	always_comb begin
		en = !out_full;
		run_act = en && (state_q == BK_RUN) && adv;
		flush = en && (((state_q == BK_RUN) && !adv && !end_q) || (state_q == BK_FLUSH));
		load = en && in_valid && ((state_q == BK_IDLE) || flush);
		place_emit = en && (state_q == BK_PLACE) && (pix_q == '0);
		tend = en && (state_q == BK_TEND);
		emit_any = (run_act && emit_req) || place_emit || tend;
		emit_ok = emit_any && (cnt_q != MAX_RESULTS);
		emit_data = emit_res;
		if (place_emit) begin
			emit_data = '0;
			emit_data.op = OP_PLACE;
			emit_data.x_coord = PLACE_COORD;
			emit_data.y_coord = PLACE_COORD;
			emit_data.image_byte = 8'h01;
		end else if (tend) begin
			emit_data = '0;
			emit_data.op = OP_TEND;
			emit_data.pixel_count = pix_q;
			emit_data.stream_offset = bytes_q;
		end
		in_pop = load;
		out_push = en && pend_v_q && (emit_ok || flush);
		out_item.last_result = flush;
		out_item.res = pend_q;
	end

	// Shift out consumed bytes, append the loaded byte
	always_ff @(posedge clk) begin
		if (run_act && cons_n != '0) begin
			for (int k = 0; k < WINDOW_DEPTH; k++) begin
				if (k + int'(cons_n) < WINDOW_DEPTH) begin
					win_q[k] <= win_q[IW'(k + int'(cons_n))];
				end
			end
		end else if (load && fill_q < FW'(WINDOW_DEPTH)) begin
			win_q[fill_q[IW-1:0]] <= in_item.data_byte;
		end
		if (emit_ok) begin
			pend_q <= emit_data;
		end
	end

	// Control and ticket state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			fill_q <= '0;
			phase_q <= PH_IDLE;
			mode_q <= '0;
			x_q <= '0;
			y_q <= '0;
			xs_q <= '0;
			xsc_q <= 8'h01;
			ysc_q <= 8'h01;
			rows_q <= '0;
			rw_q <= '0;
			rbl_q <= '0;
			col_q <= '0;
			skip_q <= '0;
			pix_q <= '0;
			bytes_q <= '0;
			end_q <= 1'b0;
			cnt_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (run_act) begin
				phase_q <= phase_d;
				mode_q <= mode_d;
				x_q <= x_d;
				y_q <= y_d;
				xs_q <= xs_d;
				xsc_q <= xsc_d;
				ysc_q <= ysc_d;
				rows_q <= rows_d;
				rw_q <= rw_d;
				rbl_q <= rbl_d;
				col_q <= col_d;
				skip_q <= skip_d;
				pix_q <= pix_d;
				fill_q <= (cons_n >= fill_q) ? '0 : fill_q - cons_n;
			end else if (tend) begin
				// Stream end: back to the reset state
				fill_q <= '0;
				phase_q <= PH_IDLE;
				mode_q <= '0;
				x_q <= '0;
				y_q <= '0;
				xs_q <= '0;
				xsc_q <= 8'h01;
				ysc_q <= 8'h01;
				rows_q <= '0;
				rw_q <= '0;
				rbl_q <= '0;
				col_q <= '0;
				skip_q <= '0;
				pix_q <= '0;
				bytes_q <= '0;
			end else if (load) begin
				if (fill_q < FW'(WINDOW_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
				bytes_q <= bytes_q + 32'd1;
				end_q <= in_item.end_of_data;
			end
			if (load) begin
				cnt_q <= '0;
			end else if (emit_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (emit_ok) begin
				pend_v_q <= 1'b1;
			end else if (flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/thermal_printer_raster_decoder_top.sv =====
// Raster decoder for a thermal-printer command stream. Bytes arrive on the slave stream, one per
// transfer, with tlast on the final byte of the stream; every image byte leaves as one draw
// command on the master stream, tlast marking the last result that a byte causes. A short input
// queue decouples the link from the parser, and an output queue lets the parser run on while
// results wait. The parser does one step of its command scan per cycle on a look-ahead window of
// WINDOW_DEPTH bytes: a dropped byte, a whole command header, a raster byte or a row abort each
// take one step. A byte first enters the window, then each step that it unlocks runs; the scan
// that finds no further step closes the byte and takes in the next one. After the final byte of
// a stream the parser adds the closing results: a place result when no pixels were drawn, then
// the end-of-stream result. The parser holds whenever the output queue is full.
`timescale 1ns / 1ps
`default_nettype none
`include "thermal_printer_raster_decoder_top_assert.svh"
module thermal_printer_raster_decoder_top #(
	parameter int WINDOW_DEPTH = tprd_pkg::WINDOW_DEPTH_DEF,
	parameter int COORD_BITS = tprd_pkg::COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata, // data_byte
	input wire logic s_axis_tlast,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// op, x_coord, y_coord, image_byte, pixel_count, stream_offset, zero fill
	output logic [tprd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast
);
	import tprd_pkg::*;

	localparam int IN_W = $bits(in_item_t);
	localparam int OUT_W = $bits(out_item_t);

	logic in_full, in_empty, in_pop;
	logic [IN_W-1:0] in_q_data;
	logic out_full, out_empty, par_out_push;
	out_item_t par_out_item;
	logic [OUT_W-1:0] out_q_data;
	out_item_t out_head;

	// Front: take bytes from the link
	assign s_axis_tready = !in_full;

	tprd_fifo #(
		.WIDTH(IN_W),
		.DEPTH(IN_FIFO_DEPTH)
	) u_in_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(s_axis_tvalid && s_axis_tready),
		.push_data({s_axis_tlast, s_axis_tdata}),
		.pop(in_pop),
		.pop_data(in_q_data),
		.full(in_full),
		.empty(in_empty)
	);

	// Back: command parser
	tprd_parser #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.COORD_BITS(COORD_BITS)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(!in_empty),
		.in_item(in_item_t'(in_q_data)),
		.in_pop(in_pop),
		.out_full(out_full),
		.out_push(par_out_push),
		.out_item(par_out_item)
	);

	// Result queue toward the master stream
	tprd_fifo #(
		.WIDTH(OUT_W),
		.DEPTH(OUT_FIFO_DEPTH)
	) u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(par_out_push),
		.push_data(par_out_item),
		.pop(m_axis_tvalid && m_axis_tready),
		.pop_data(out_q_data),
		.full(out_full),
		.empty(out_empty)
	);

	assign out_head = out_item_t'(out_q_data);
	assign m_axis_tvalid = !out_empty;
	assign m_axis_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_head.res};
	assign m_axis_tlast = out_head.last_result;

	`TPRD_ASSERT_IMPLIES(a_push_has_room, clk, arst_n, par_out_push, !out_full)
	`TPRD_ASSERT_IMPLIES(a_pop_has_data, clk, arst_n, in_pop, !in_empty)
	`TPRD_ASSERT_NEXT(a_push_shows, clk, arst_n, par_out_push, m_axis_tvalid)
	`TPRD_ASSERT_IMPLIES(a_op_known, clk, arst_n, m_axis_tvalid, m_axis_tdata[2:0] <= 3'(OP_TEND))
endmodule
`default_nettype wire
